FILE: src/bgr_pkg.sv
// Package for the bitmap glyph rasteriser: payload, descriptor and config types,
// screen constants and the RGB888 to RGB565 reduction. No dependencies.
package bgr_pkg;

   localparam int SCREEN_WIDTH  = 480;
   localparam int SCREEN_HEIGHT = 272;

   localparam int COL_W  = $clog2(SCREEN_WIDTH);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int IDX_W  = 17;
   localparam int CALC_W = (ROW_W + COL_W + 1 > IDX_W) ? ROW_W + COL_W + 1 : IDX_W;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPARENT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_HEIGHT = 3'd4;

   localparam logic CMD_SET_POS = 1'b0;
   localparam logic CMD_GLYPH   = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         glyph_bits;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
      logic [15:0]      pixel_color;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] fg_color;
      logic [23:0] bg_color;
      logic        transparent;
      logic [6:0]  glyph_width;
      logic [6:0]  glyph_height;
   } cfg_type;

   // One glyph byte's worth of work: row, first column and which of the
   // eight pixels to write (bit i is glyph pixel i from the left).
   typedef struct packed {
      logic [ROW_W-1:0] py;
      logic [COL_W-1:0] px_base;
      logic [7:0]       mask;
      logic [7:0]       setv;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   function automatic logic [15:0] to565(input logic [23:0] c);
      return {c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

FILE: src/bgr_fifo.sv
// Short descriptor queue between the front and back ends of the rasteriser.
// Depends on bgr_pkg.
module bgr_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bgr_pkg::desc_type        push_data,
   input  logic                     pop,
   output bgr_pkg::desc_type        head,
   output bgr_pkg::fifo_status_type status
);

   bgr_pkg::desc_type                 entry_ff [bgr_pkg::FIFO_DEPTH];
   logic [bgr_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bgr_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bgr_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == bgr_pkg::FIFO_CNT_W'(bgr_pkg::FIFO_DEPTH));

endmodule

FILE: src/bgr_front.sv
// Front end: accepts commands, keeps the caret and glyph position, clips one
// glyph byte and queues a pixel descriptor. Depends on bgr_pkg.
module bgr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  bgr_pkg::cfg_type         cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bgr_pkg::req_type         req_data,
   input  bgr_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output bgr_pkg::desc_type        push_data
);

   logic signed [15:0] caret_x_ff, caret_x_in;
   logic signed [15:0] caret_y_ff, caret_y_in;
   logic [6:0]         row_ff, row_in;
   logic [6:0]         column_ff, column_in;

   logic               accept;
   logic [6:0]         w, h;
   logic signed [17:0] cx, cy, py, px_base_full;
   logic signed [17:0] px [8];
   logic [7:0]         col [8];
   logic               onscreen, draw, py_ok;
   logic [7:0]         mask, setv;
   logic [7:0]         col_next, row_next;

   assign req_ready = !fifo_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      w  = (cfg.glyph_width  == '0) ? 7'd1 : cfg.glyph_width;
      h  = (cfg.glyph_height == '0) ? 7'd1 : cfg.glyph_height;
      cx = 18'(caret_x_ff);
      cy = 18'(caret_y_ff);

      onscreen = !(cx >= 18'(bgr_pkg::SCREEN_WIDTH) || cy >= 18'(bgr_pkg::SCREEN_HEIGHT) ||
                   cx + signed'(18'(w)) < 18'sd1 || cy + signed'(18'(h)) < 18'sd1);
      draw  = onscreen && (row_ff < h);
      py    = cy + signed'(18'(row_ff));
      py_ok = (py >= 18'sd0) && (py < 18'(bgr_pkg::SCREEN_HEIGHT));

      for (int i = 0; i < 8; i++) begin
         col[i]  = {1'b0, column_ff} + 8'(i);
         px[i]   = cx + signed'(18'(col[i]));
         setv[i] = req_data.glyph_bits[7-i];
         mask[i] = draw && py_ok && (col[i] < {1'b0, w}) &&
                   (px[i] >= 18'sd0) && (px[i] < 18'(bgr_pkg::SCREEN_WIDTH)) &&
                   (setv[i] || !cfg.transparent);
      end

      px_base_full      = cx + signed'(18'(column_ff));
      push_data.py      = py[bgr_pkg::ROW_W-1:0];
      push_data.px_base = px_base_full[bgr_pkg::COL_W-1:0];
      push_data.mask    = mask;
      push_data.setv    = setv;
      push = accept && (req_data.command == bgr_pkg::CMD_GLYPH) && (mask != '0);
   end

   // Caret and glyph position update.
   always_comb begin
      caret_x_in = caret_x_ff;
      caret_y_in = caret_y_ff;
      row_in     = row_ff;
      column_in  = column_ff;
      col_next   = {1'b0, column_ff} + 8'd8;
      row_next   = {1'b0, row_ff} + 8'd1;
      if (accept) begin
         if (req_data.command == bgr_pkg::CMD_SET_POS) begin
            caret_x_in = req_data.pos_x;
            caret_y_in = req_data.pos_y;
            row_in     = '0;
            column_in  = '0;
         end else if (col_next >= {1'b0, w}) begin
            column_in = '0;
            if (row_next >= {1'b0, h}) begin
               row_in = '0;
               if (onscreen) begin
                  caret_x_in = caret_x_ff + signed'(16'(w));
               end
            end else begin
               row_in = row_next[6:0];
            end
         end else begin
            column_in = col_next[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         caret_x_ff <= '0;
         caret_y_ff <= '0;
         row_ff     <= '0;
         column_ff  <= '0;
      end else begin
         caret_x_ff <= caret_x_in;
         caret_y_ff <= caret_y_in;
         row_ff     <= row_in;
         column_ff  <= column_in;
      end
   end

endmodule

FILE: src/bgr_back.sv
// Back end: walks the queued pixel mask left to right, one pixel write per
// cycle while rsp_ready allows, into a registered output. Depends on bgr_pkg.
module bgr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bgr_pkg::cfg_type         cfg,
   input  bgr_pkg::desc_type        head,
   input  bgr_pkg::fifo_status_type fifo_status,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bgr_pkg::rsp_type         rsp_data
);

   logic [7:0]                 mask_ff, mask_in;
   logic [bgr_pkg::ROW_W-1:0]  py_ff, py_in;
   logic [bgr_pkg::COL_W-1:0]  px_base_ff, px_base_in;
   logic [7:0]                 setv_ff, setv_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bgr_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       out_free, emit, need_load, found;
   logic [2:0]                 sel;
   logic [7:0]                 onehot, rest;
   logic [bgr_pkg::COL_W-1:0]  px;
   logic [bgr_pkg::CALC_W-1:0] calc;

   // Pick the leftmost pending pixel.
   always_comb begin
      sel    = '0;
      found  = 1'b0;
      onehot = '0;
      for (int i = 0; i < 8; i++) begin
         if (mask_ff[i] && !found) begin
            sel       = 3'(i);
            onehot[i] = 1'b1;
            found     = 1'b1;
         end
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      emit      = out_free && (mask_ff != '0);
      rest      = mask_ff & ~onehot;
      need_load = (mask_ff == '0) || (emit && (rest == '0));
      pop       = need_load && !fifo_status.empty;

      mask_in    = emit ? rest : mask_ff;
      py_in      = py_ff;
      px_base_in = px_base_ff;
      setv_in    = setv_ff;
      if (pop) begin
         mask_in    = head.mask;
         py_in      = head.py;
         px_base_in = head.px_base;
         setv_in    = head.setv;
      end

      px   = px_base_ff + bgr_pkg::COL_W'(sel);
      calc = bgr_pkg::CALC_W'(py_ff) * bgr_pkg::CALC_W'(bgr_pkg::SCREEN_WIDTH) +
             bgr_pkg::CALC_W'(px);

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_data_in.pixel_index = calc[bgr_pkg::IDX_W-1:0];
         rsp_data_in.pixel_color = setv_ff[sel] ? bgr_pkg::to565(cfg.fg_color)
                                                : bgr_pkg::to565(cfg.bg_color);
         rsp_data_in.last        = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      py_ff       <= py_in;
      px_base_ff  <= px_base_in;
      setv_ff     <= setv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/bitmap_glyph_rasterizer.sv
// Top level of the monochrome bitmap glyph rasteriser: configuration registers
// and the front end, descriptor queue and back end. Depends on bgr_pkg.
//
// The block takes caret commands and glyph bytes (MSB leftmost, ceil(width/8)
// bytes per glyph row) and produces pixel writes as a screen pixel index and
// an RGB565 colour, with last marking the final write caused by a byte. The
// front end takes one item per cycle while the two-entry descriptor queue has
// room; caret commands and bytes with no visible pixel finish there and produce
// nothing. The back end issues one pixel write per cycle while rsp_ready does
// not hold it, so a glyph byte costs it one to eight writes, one per written
// pixel; that single write port sets the sustained rate. Results sit in an
// output register, so the next byte is taken while a write waits for rsp_ready.
// Configuration writes land at once; change them only with the block idle.
module bitmap_glyph_rasterizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bgr_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bgr_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_en,
   input  logic [bgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bgr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bgr_pkg::cfg_type         cfg_ff, cfg_in;
   bgr_pkg::desc_type        push_data, head;
   bgr_pkg::fifo_status_type fifo_status;
   logic                     push, pop;

   // Register file: decode the index and drop writes beyond the list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            bgr_pkg::CSR_FG_COLOR:     cfg_in.fg_color     = csr_wdata;
            bgr_pkg::CSR_BG_COLOR:     cfg_in.bg_color     = csr_wdata;
            bgr_pkg::CSR_TRANSPARENT:  cfg_in.transparent  = csr_wdata[0];
            bgr_pkg::CSR_GLYPH_WIDTH:  cfg_in.glyph_width  = csr_wdata[6:0];
            bgr_pkg::CSR_GLYPH_HEIGHT: cfg_in.glyph_height = csr_wdata[6:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color     <= 24'hFFFFFF;
         cfg_ff.bg_color     <= 24'h000000;
         cfg_ff.transparent  <= 1'b1;
         cfg_ff.glyph_width  <= 7'd8;
         cfg_ff.glyph_height <= 7'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify and clip each item; queue only bytes that write something.
   bgr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   // Decouple the front from stalls on the result side.
   bgr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (fifo_status)
   );

   // Emit one pixel write per transfer.
   bgr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
